### rtl/sbas_frame_checker_macros.svh
// Assertion helpers shared by the frame checker RTL.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef SBAS_FRAME_CHECKER_MACROS_SVH
`define SBAS_FRAME_CHECKER_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define SBASFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define SBASFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sbasfc_pkg.sv
`default_nettype none

package sbasfc_pkg;

  // Frame geometry
  localparam int unsigned FrameWords = 8;
  localparam int unsigned WordW      = 32;
  localparam int unsigned MsgW       = FrameWords * WordW;
  localparam int unsigned SlotW      = $clog2(FrameWords);
  localparam int unsigned CntW       = 4;
  localparam int unsigned CrcW       = 24;
  localparam int unsigned PrnW       = 8;
  localparam int unsigned TowW       = 30;
  localparam int unsigned TypeW      = 6;
  localparam int unsigned SenderW    = 16;
  localparam int unsigned ChunkW     = 64;
  localparam int unsigned ChunkIdxW  = 2;

  // Message bit positions (bit 0 is the first transmitted bit)
  localparam int unsigned PayloadStart = 14;
  localparam int unsigned DataBits     = 226;
  localparam int unsigned PayloadW     = DataBits - PayloadStart;
  localparam int unsigned TailW        = PayloadW - 3 * ChunkW;
  localparam int unsigned LastSlotBits = DataBits - WordW * (FrameWords - 1);

  // Word counter limits
  localparam logic [CntW-1:0] CntMax     = 4'd15;
  localparam logic [CntW-1:0] CntFull    = CntW'(FrameWords);
  localparam logic [CntW-1:0] CntFullPl1 = CntW'(FrameWords + 1);
  localparam logic [CntW-1:0] CntLastIdx = CntW'(FrameWords - 1);

  // Preamble bytes
  localparam logic [7:0] PreambleA = 8'h53;
  localparam logic [7:0] PreambleB = 8'h9A;
  localparam logic [7:0] PreambleC = 8'hC6;

  // CRC-24Q, polynomial 0x1864CFB without its top term
  localparam logic [CrcW-1:0] CrcPoly = 24'h864CFB;

  // Register indexes and reset values
  localparam logic CfgFirstPrn = 1'b0;
  localparam logic CfgPrnCount = 1'b1;
  localparam logic [PrnW-1:0] FirstPrnRst = 8'd120;
  localparam logic [PrnW-1:0] PrnCountRst = 8'd19;

  // Chunk codes
  localparam logic [ChunkIdxW-1:0] ChunkFirst = 2'd0;
  localparam logic [ChunkIdxW-1:0] ChunkTwo   = 2'd1;
  localparam logic [ChunkIdxW-1:0] ChunkThree = 2'd2;
  localparam logic [ChunkIdxW-1:0] ChunkLast  = 2'd3;

  // Validated frame handed to the result stage
  typedef struct packed {
    logic [PrnW-1:0]     prn;
    logic [TowW-1:0]     tow;
    logic [TypeW-1:0]    mtype;
    logic [SenderW-1:0]  sender;
    logic [PayloadW-1:0] payload;
  } sbasfc_result_t;

  // Parallel CRC-24Q over one word, MSB first; short_word covers only the
  // leading bits of the final slot
  function automatic logic [CrcW-1:0] crc24q_word(logic [CrcW-1:0] crc_in,
                                                  logic [WordW-1:0] word,
                                                  logic short_word);
    logic [CrcW-1:0] crc;
    logic            fb;
    crc = crc_in;
    for (int i = 0; i < WordW; i++) begin
      if (!short_word || (i < LastSlotBits)) begin
        fb  = crc[CrcW-1] ^ word[WordW-1-i];
        crc = {crc[CrcW-2:0], 1'b0} ^ (fb ? CrcPoly : '0);
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

### rtl/sbasfc_chunk_out.sv
`default_nettype none

module sbasfc_chunk_out
  import sbasfc_pkg::*;
(
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       load_i,
  input  sbasfc_result_t            result_i,
  output logic                      busy_o,
  output logic                      out_valid_o,
  input  wire                       out_stall_i,
  output logic [PrnW-1:0]           prn_out_o,
  output logic [TowW-1:0]           tow_out_o,
  output logic [TypeW-1:0]          msg_type_o,
  output logic [SenderW-1:0]        sender_out_o,
  output logic [ChunkIdxW-1:0]      chunk_index_o,
  output logic [ChunkW-1:0]         payload_chunk_o,
  output logic                      last_chunk_o
);

  logic                 valid_q;
  logic [ChunkIdxW-1:0] chunk_q;
  sbasfc_result_t       res_q;

  // Advance through the four chunks; a new frame must only be loaded when empty (not enforced here)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      chunk_q <= ChunkFirst;
    end else if (load_i) begin
      valid_q <= 1'b1;
      chunk_q <= ChunkFirst;
    end else if (valid_q && !out_stall_i) begin
      if (chunk_q == ChunkLast) begin
        valid_q <= 1'b0;
      end else begin
        chunk_q <= chunk_q + 2'd1;
      end
    end
  end

  // Hold the frame contents
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  // Select the current chunk, MSB first
  always_comb begin
    unique case (chunk_q)
      ChunkFirst: payload_chunk_o = res_q.payload[PayloadW-1 -: ChunkW];
      ChunkTwo:   payload_chunk_o = res_q.payload[PayloadW-1-ChunkW -: ChunkW];
      ChunkThree: payload_chunk_o = res_q.payload[PayloadW-1-2*ChunkW -: ChunkW];
      ChunkLast:  payload_chunk_o = {{(ChunkW-TailW){1'b0}}, res_q.payload[TailW-1:0]};
      default:    payload_chunk_o = '0;
    endcase
  end

  assign busy_o         = valid_q;
  assign out_valid_o    = valid_q;
  assign prn_out_o      = res_q.prn;
  assign tow_out_o      = res_q.tow;
  assign msg_type_o     = res_q.mtype;
  assign sender_out_o   = res_q.sender;
  assign chunk_index_o  = chunk_q;
  assign last_chunk_o   = (chunk_q == ChunkLast);

endmodule

`default_nettype wire

### rtl/sbas_frame_checker.sv
// Channel   Handshake                 Payload
// input     in_valid_i / in_stall_o   word_in_i frame_end_i prn_in_i tow_in_i sender_in_i
// output    out_valid_o / out_stall_i prn_out_o tow_out_o msg_type_o sender_out_o
//                                     chunk_index_o payload_chunk_o last_chunk_o
// config    cfg_we_i                  cfg_index_i cfg_data_i
//
// One word is taken per cycle unless stalled; its CRC-24Q update is a 32-bit
// parallel XOR network feeding the frame registers.
// A valid frame is copied into the result stage on its closing word and
// leaves as four transactions, one per cycle unless stalled.
// The input stalls only while that stage still holds a frame and the
// current frame has seven or more words, so it could close a valid frame.
// Reset clears the word counter and CRC and sets the config registers to their reset values; no clearing pass.
`default_nettype none

`include "sbas_frame_checker_macros.svh"

module sbas_frame_checker
  import sbasfc_pkg::*;
(
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // configuration
  input  wire                   cfg_we_i,
  input  wire                   cfg_index_i,
  input  wire  [PrnW-1:0]       cfg_data_i,
  // input words
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  wire  [WordW-1:0]      word_in_i,
  input  wire                   frame_end_i,
  input  wire  [PrnW-1:0]       prn_in_i,
  input  wire  [TowW-1:0]       tow_in_i,
  input  wire  [SenderW-1:0]    sender_in_i,
  // results
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output logic [PrnW-1:0]       prn_out_o,
  output logic [TowW-1:0]       tow_out_o,
  output logic [TypeW-1:0]      msg_type_o,
  output logic [SenderW-1:0]    sender_out_o,
  output logic [ChunkIdxW-1:0]  chunk_index_o,
  output logic [ChunkW-1:0]     payload_chunk_o,
  output logic                  last_chunk_o
);

  logic [WordW-1:0] fw_q [FrameWords];
  logic [WordW-1:0] fw_d [FrameWords];
  logic [CntW-1:0]  cnt_q, cnt_d, cnt_inc;
  logic [CrcW-1:0]  crc_q, crc_d, crc_new;
  logic [PrnW-1:0]  first_prn_q, prn_count_q;

  logic           accept;
  logic           store;
  logic           last_slot;
  logic           count_ok, prn_ok, pre_ok, crc_ok;
  logic [PrnW:0]  prn_limit;
  logic [7:0]     preamble;
  logic [MsgW-1:0] msg;
  logic           res_load;
  logic           out_busy;
  sbasfc_result_t result;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = out_busy && (cnt_q >= CntLastIdx);

  // Store the first eight words and fold them into the CRC
  assign store     = (cnt_q < CntFull);
  assign last_slot = (cnt_q == CntLastIdx);
  assign crc_new   = store ? crc24q_word(crc_q, word_in_i, last_slot) : crc_q;
  assign cnt_inc   = (cnt_q == CntMax) ? cnt_q : cnt_q + 4'd1;

  always_comb begin
    for (int w = 0; w < FrameWords; w++) begin
      fw_d[w] = fw_q[w];
    end
    if (store) begin
      fw_d[cnt_q[SlotW-1:0]] = word_in_i;
    end
  end

  // Restart counting and CRC after the closing word
  assign cnt_d = frame_end_i ? '0 : cnt_inc;
  assign crc_d = frame_end_i ? '0 : crc_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      crc_q <= '0;
    end else if (accept) begin
      cnt_q <= cnt_d;
      crc_q <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int w = 0; w < FrameWords; w++) begin
        fw_q[w] <= fw_d[w];
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_prn_q <= FirstPrnRst;
      prn_count_q <= PrnCountRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgFirstPrn: first_prn_q <= cfg_data_i;
        CfgPrnCount: prn_count_q <= cfg_data_i;
        default:     first_prn_q <= first_prn_q;
      endcase
    end
  end

  // Frame checks on the closing word
  assign count_ok  = (cnt_inc == CntFull) || (cnt_inc == CntFullPl1);
  assign prn_limit = {1'b0, first_prn_q} + {1'b0, prn_count_q};
  assign prn_ok    = (prn_in_i >= first_prn_q) && ({1'b0, prn_in_i} < prn_limit);
  assign preamble  = fw_d[0][WordW-1 -: 8];
  assign pre_ok    = (preamble == PreambleA) || (preamble == PreambleB) ||
                     (preamble == PreambleC);
  assign crc_ok    = (fw_d[FrameWords-1][WordW-1-LastSlotBits -: CrcW] == crc_new);
  assign res_load  = accept && frame_end_i && count_ok && prn_ok && pre_ok && crc_ok;

  // Flatten the frame so that message bit 0 sits at the top
  always_comb begin
    for (int w = 0; w < FrameWords; w++) begin
      msg[MsgW-1-w*WordW -: WordW] = fw_d[w];
    end
  end

  assign result.prn     = prn_in_i;
  assign result.tow     = tow_in_i;
  assign result.mtype   = fw_d[0][WordW-1-8 -: TypeW];
  assign result.sender  = sender_in_i;
  assign result.payload = msg[MsgW-1-PayloadStart -: PayloadW];

  sbasfc_chunk_out u_chunk_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (res_load),
    .result_i        (result),
    .busy_o          (out_busy),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .prn_out_o       (prn_out_o),
    .tow_out_o       (tow_out_o),
    .msg_type_o      (msg_type_o),
    .sender_out_o    (sender_out_o),
    .chunk_index_o   (chunk_index_o),
    .payload_chunk_o (payload_chunk_o),
    .last_chunk_o    (last_chunk_o)
  );

  // A validated frame never overwrites one still being sent
  `SBASFC_ASSERT_NOW(a_load_when_free, res_load, !out_busy, "frame loaded while result stage busy")

  // Chunks of one frame follow each other without a gap
  `SBASFC_ASSERT_NEXT(a_chunks_continue, out_valid_o && !out_stall_i && !last_chunk_o, out_valid_o && (chunk_index_o == $past(chunk_index_o) + 2'd1), "chunk sequence broken")

  // The closing word leaves counter and CRC cleared
  `SBASFC_ASSERT_NEXT(a_frame_end_clears, accept && frame_end_i, (cnt_q == '0) && (crc_q == '0), "frame state not cleared")

endmodule

`default_nettype wire
